[design/spn_pkg.sv]
package spn_pkg;

  localparam int BLOCK_W    = 24;
  localparam int SLICE_W    = 6;
  localparam int SLICES     = 4;
  localparam int SBOX_DEPTH = 64;
  localparam int PERM_DEPTH = 24;
  localparam int PERM_W     = 5;
  localparam int INDEX_W    = 6;

  typedef enum logic [1:0] {
    OP_ENC  = 2'd0,
    OP_SBOX = 2'd1,
    OP_PERM = 2'd2,
    OP_KEY  = 2'd3
  } op_t;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [SLICE_W-1:0] slice_t;
  typedef logic [PERM_W-1:0]  perm_t;

endpackage

[design/spn_block_encrypt_24bit_core.sv]
// 24-bit SPN block encryptor, ECB, one round per pipeline stage.
//
// Input channel (in_*): each word carries an opcode. OP_ENC encrypts
// in_payload; OP_SBOX / OP_PERM / OP_KEY load an S-box entry, a permutation
// entry or a round key and produce no result. Out-of-range permutation or
// key indexes are dropped.
// Result channel (out_*): one word per encrypted block, in order, with
// in_last_block copied to out_last_out.
//
// Pipeline: the accepting edge already registers the round-1 S-box read,
// each later round registers one more, and the output register adds the
// final key XOR. Encrypt words are taken every cycle while out_stall does
// not freeze the pipeline, so throughput is one block per clock. A table
// write is held on in_stall until the round stages are empty, and only then
// accepted; this keeps blocks already in flight on the old tables.
//
// Reset clears all stage valid bits and the output valid; table contents
// are undefined until loaded. When out_stall is high with a result pending,
// the whole pipeline freezes and in_stall is raised; nothing is lost.
module spn_block_encrypt_24bit_core #(
  parameter int ROUNDS = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_opcode,
  input  logic [5:0]              in_index,
  input  logic [23:0]             in_payload,
  input  logic                    in_last_block,
  output logic                    out_valid,
  input  logic                    out_stall,
  output spn_pkg::block_t         out_cipher_block,
  output logic                    out_last_out
);
  import spn_pkg::*;

  localparam int KEY_DEPTH = ROUNDS + 1;
  localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

  // tables
  block_t key_r  [KEY_DEPTH];
  perm_t  perm_r [PERM_DEPTH];

  // round stage pipeline
  logic [ROUNDS-1:0] v_r;
  logic [ROUNDS-1:0] lst_r;
  block_t            sd    [ROUNDS];   // registered S-box output per round
  block_t            rin   [ROUNDS];   // S-box address word per round

  logic   out_valid_r;
  block_t out_data_r;
  logic   out_last_r;

  logic en;
  logic busy;
  logic in_acc;
  logic is_write;
  op_t  op;

  assign op       = op_t'(in_opcode);
  assign is_write = (op != OP_ENC);
  assign busy     = |v_r;
  // freeze everything while a result waits on a stalled receiver
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en || (in_valid && is_write && busy);
  assign in_acc   = in_valid && !in_stall;

  // ---- table loads ----
  always_ff @(posedge clk) begin
    if (in_acc) begin
      case (op)
        OP_PERM: begin
          if (in_index < 6'(PERM_DEPTH)) perm_r[in_index[PERM_W-1:0]] <= in_payload[PERM_W-1:0];
        end
        OP_KEY: begin
          if (in_index < 6'(KEY_DEPTH)) key_r[in_index[KEY_AW-1:0]] <= in_payload;
        end
        default: ;
      endcase
    end
  end

  // ---- S-box address words: key XOR, after the permutation from round 2 on ----
  always_comb begin
    logic [31:0] ext;
    for (int r = 0; r < ROUNDS; r++) begin
      if (r == 0) begin
        rin[r] = in_payload ^ key_r[0];
      end else begin
        ext = {8'b0, sd[r-1]};
        for (int i = 0; i < PERM_DEPTH; i++) begin
          // source entries 24..31 pick the zero pad
          rin[r][i] = ext[perm_r[i]];
        end
        rin[r] = rin[r] ^ key_r[r];
      end
    end
  end

  // ---- S-box copies: one 64x6 memory per lookup, registered read ----
  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    for (genvar s = 0; s < SLICES; s++) begin : g_slice
      slice_t mem [SBOX_DEPTH];
      slice_t rd_r;

      always_ff @(posedge clk) begin
        if (in_acc && (op == OP_SBOX)) mem[in_index] <= in_payload[SLICE_W-1:0];
      end

      always_ff @(posedge clk) begin
        if (en) rd_r <= mem[rin[r][s*SLICE_W +: SLICE_W]];
      end

      assign sd[r][s*SLICE_W +: SLICE_W] = rd_r;
    end
  end

  // ---- stage control ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r[0]      <= in_acc && !is_write;
      for (int r = 1; r < ROUNDS; r++) v_r[r] <= v_r[r-1];
      out_valid_r <= v_r[ROUNDS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lst_r[0]   <= in_last_block;
      for (int r = 1; r < ROUNDS; r++) lst_r[r] <= lst_r[r-1];
      out_last_r <= lst_r[ROUNDS-1];
      out_data_r <= sd[ROUNDS-1] ^ key_r[ROUNDS];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cipher_block = out_data_r;
  assign out_last_out     = out_last_r;

  // ---- assertions ----
  a_no_write_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_write) |-> !busy)
    else $error("table write accepted with blocks in flight");

  a_enc_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_write) |=> v_r[0])
    else $error("accepted encrypt did not enter round stage");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("stage valids moved during stall");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v_r[ROUNDS-1]))
    else $error("result without a block in the last round stage");

endmodule

[verif/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spn_pkg::*;

  localparam int ROUNDS    = 4;
  // The result channel can be held off on purpose for this many cycles.
  localparam int LONG_HOLD = 300;
  // Cycles without any accepted word before the run is declared hung.
  localparam int WDOG_LIMIT = 2000;

  typedef struct {
    block_t cipher;
    logic   last_mark;
  } cipher_word_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [1:0]         in_opcode     = OP_ENC;
  logic [INDEX_W-1:0] in_index      = '0;
  block_t             in_payload    = '0;
  logic               in_last_block = 1'b0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  block_t             out_cipher_block;
  logic               out_last_out;

  always #10 clk = ~clk;

  spn_block_encrypt_24bit_core #(
    .ROUNDS(ROUNDS)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_index        (in_index),
    .in_payload      (in_payload),
    .in_last_block   (in_last_block),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cipher_block(out_cipher_block),
    .out_last_out    (out_last_out)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the cipher tables. It is updated in acceptance order, which
  // matches the DUT: a table write waits until the round stages drain, so
  // blocks in flight always see the tables as they were when they entered.
  // ---------------------------------------------------------------------------
  slice_t sbox_img [SBOX_DEPTH];
  perm_t  perm_img [PERM_DEPTH];
  block_t key_img  [ROUNDS+1];

  // Cipher words still owed by the DUT, oldest first.
  cipher_word_t pending_cipher_q[$];

  int err_cnt       = 0;
  int snd_idle_pct  = 0;   // chance per cycle that the sender idles
  int rcv_stall_pct = 0;   // chance per cycle that the receiver stalls
  bit long_hold_req = 1'b0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  // Four S-box lookups, most significant 6-bit slice first.
  function automatic block_t sbox_layer(block_t w);
    block_t r;
    for (int s = SLICES - 1; s >= 0; s--)
      r[s*SLICE_W +: SLICE_W] = sbox_img[w[s*SLICE_W +: SLICE_W]];
    return r;
  endfunction

  // Full encryption of one block with the current shadow tables.
  function automatic block_t encrypt_block(block_t plain);
    block_t w;
    block_t p;
    w = plain;
    for (int r = 0; r < ROUNDS - 1; r++) begin
      w = sbox_layer(w ^ key_img[r]);
      // new bit i takes old bit perm[i]; sources above bit 23 read as zero
      p = '0;
      for (int i = 0; i < PERM_DEPTH; i++)
        if (perm_img[i] < BLOCK_W) p[i] = w[perm_img[i]];
      w = p;
    end
    return sbox_layer(w ^ key_img[ROUNDS-1]) ^ key_img[ROUNDS];
  endfunction

  // ---------------------------------------------------------------------------
  // Send one word on the input channel. Called at a falling edge, returns at a
  // falling edge. in_valid is written at most once per time step: an idle gap
  // lowers it, otherwise it stays high from the previous word.
  // ---------------------------------------------------------------------------
  task automatic send_word(op_t op, logic [INDEX_W-1:0] idx, block_t pay, logic last);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_index      <= idx;
    in_payload    <= pay;
    in_last_block <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    // accepted at this edge: advance the shadow state
    case (op)
      OP_ENC:  pending_cipher_q.push_back('{cipher: encrypt_block(pay), last_mark: last});
      OP_SBOX: sbox_img[idx] = pay[SLICE_W-1:0];
      OP_PERM: if (idx < PERM_DEPTH) perm_img[idx] = pay[PERM_W-1:0];
      OP_KEY:  if (idx <= ROUNDS) key_img[idx] = pay;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fill every table entry before the first encrypt, so no unwritten entry is
  // ever read. Upper payload bits carry junk that must be dropped.
  task automatic test_load_tables();
    int     order [PERM_DEPTH];
    int     j;
    int     t;
    block_t pay;
    for (int i = 0; i < SBOX_DEPTH; i++)
      send_word(OP_SBOX, INDEX_W'(i), block_t'($urandom), 1'($urandom_range(1)));
    // a shuffled bit order gives real diffusion
    for (int i = 0; i < PERM_DEPTH; i++) order[i] = i;
    for (int i = PERM_DEPTH - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < PERM_DEPTH; i++) begin
      pay             = block_t'($urandom);
      pay[PERM_W-1:0] = PERM_W'(order[i]);
      send_word(OP_PERM, INDEX_W'(i), pay, 1'($urandom_range(1)));
    end
    for (int i = 0; i <= ROUNDS; i++)
      send_word(OP_KEY, INDEX_W'(i), block_t'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic test_directed();
    // payload extremes, both values of last_block, back to back
    send_word(OP_ENC, 6'd0,  24'h000000, 1'b0);
    send_word(OP_ENC, 6'd63, 24'hFFFFFF, 1'b1);
    send_word(OP_ENC, 6'd0,  24'hAAAAAA, 1'b0);
    send_word(OP_ENC, 6'd21, 24'h555555, 1'b1);
    // out-of-range permutation and key indexes are dropped
    send_word(OP_PERM, 6'd24,             24'h000000, 1'b0);
    send_word(OP_PERM, 6'd63,             24'hFFFFFF, 1'b1);
    send_word(OP_KEY,  INDEX_W'(ROUNDS+1), 24'hFFFFFF, 1'b0);
    send_word(OP_KEY,  6'd63,             24'h123456, 1'b0);
    send_word(OP_ENC,  6'd0,              24'hFFFFFF, 1'b0);
    // permutation sources 24..31 point past the block and read as zero
    send_word(OP_PERM, 6'd0,  24'hFFFFFF, 1'b0);
    send_word(OP_PERM, 6'd23, 24'h000018, 1'b1);
    send_word(OP_ENC,  6'd0,  24'hFFFFFF, 1'b1);
    send_word(OP_ENC,  6'd0,  24'h000000, 1'b0);
    // wide sbox values keep only the low 6 bits; last_block is ignored on writes
    send_word(OP_SBOX, 6'd63,            24'hFFFFC0, 1'b1);
    send_word(OP_SBOX, 6'd0,             24'hFFFFFF, 1'b1);
    send_word(OP_KEY,  6'd0,             24'hFFFFFF, 1'b1);
    send_word(OP_KEY,  INDEX_W'(ROUNDS), 24'h000000, 1'b0);
    send_word(OP_ENC,  6'd0,             24'hFFFFFF, 1'b0);
    send_word(OP_ENC,  6'd63,            24'h000000, 1'b1);
  endtask

  // Mostly encrypts with random content; the rest are table writes over the
  // full index range, so dropped writes and far permutation sources recur.
  task automatic test_random(int n_words, int snd_pct, int rcv_pct);
    op_t op;
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    for (int k = 0; k < n_words; k++) begin
      if ($urandom_range(99) < 80) op = OP_ENC;
      else                         op = op_t'($urandom_range(3, 1));
      send_word(op, INDEX_W'($urandom_range(63)), block_t'($urandom), 1'($urandom_range(1)));
    end
  endtask

  // Receiver goes quiet for a long stretch while the sender keeps pushing
  // encrypts: the pipeline fills and in_stall must come up without loss.
  task automatic test_backpressure();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    long_hold_req = 1'b1;
    repeat (40)
      send_word(OP_ENC, INDEX_W'($urandom_range(63)), block_t'($urandom),
                1'($urandom_range(1)));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall, driven at the falling edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left     = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted word against the oldest pending cipher.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : chk_cipher
    cipher_word_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_cipher_q.size() == 0) begin
        $error("unexpected result word: cipher_block %06h last_out %0b",
               out_cipher_block, out_last_out);
        err_cnt++;
      end else begin
        want = pending_cipher_q.pop_front();
        if (out_cipher_block !== want.cipher) begin
          $error("cipher_block: expected %06h, got %06h", want.cipher, out_cipher_block);
          err_cnt++;
        end
        if (out_last_out !== want.last_mark) begin
          $error("last_out: expected %0b, got %0b", want.last_mark, out_last_out);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: no word moving on either channel for too long means a hang.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("[spn_block_encrypt_24bit_core] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_load_tables();
    test_directed();
    test_random(240, 16, 72);   // busy sender, sparse receiver
    test_random(240, 72, 16);   // sparse sender, busy receiver
    test_backpressure();
    test_random(120, 0, 0);     // full rate both ways
    in_valid <= 1'b0;

    // drain, then give the pipeline time to show any stray word
    while (pending_cipher_q.size() != 0) @(posedge clk);
    repeat (ROUNDS + 4) @(posedge clk);

    if (err_cnt == 0)
      $display("[spn_block_encrypt_24bit_core] OK");
    else
      $display("[spn_block_encrypt_24bit_core] ERROR");
    $finish;
  end

endmodule
